@@ rtl/rhsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Rolling hash string matcher package
// Shared widths, register codes, item structs, unit handshakes and FSM states.
// ----------------------------------------------------------------------------
package rhsm_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RADIX_W = 9;
  localparam int unsigned MOD_W   = 31;
  localparam int unsigned SHIFT_W = 32;

  // Modular unit: a 32-bit operand times a 9-bit operand plus a byte.
  localparam int unsigned MR_A_W   = 32;
  localparam int unsigned MR_PW    = MR_A_W + RADIX_W;
  localparam int unsigned MR_CNT_W = $clog2(MR_PW + 1);

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_RADIX   = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  localparam logic [RADIX_W-1:0] RADIX_RST   = 9'd256;
  localparam logic [MOD_W-1:0]   MODULUS_RST = 31'd65536;

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_TEXT    = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] byte_value;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic               window_full;
    logic               hash_hit;
    logic               match;
    logic [SHIFT_W-1:0] shift;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [MR_A_W-1:0]  a;
    logic [RADIX_W-1:0] b;
    logic [BYTE_W-1:0]  c;
  } mr_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } mr_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASH,
    ST_PHASH_W,
    ST_PPOW,
    ST_PPOW_W,
    ST_TFILL,
    ST_TFILL_W,
    ST_SRD,
    ST_STERM,
    ST_STERM_W,
    ST_SHASH,
    ST_SHASH_W,
    ST_EVAL,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_OUT
  } state_t;

endpackage

@@ rtl/rhsm_modred.sv @@
// ----------------------------------------------------------------------------
// Serial modular multiply-add unit
// Computes (a * b + c) mod q, one remainder bit per cycle.
// ----------------------------------------------------------------------------
module rhsm_modred (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rhsm_pkg::mr_req_t            req,
  input  logic [rhsm_pkg::MOD_W-1:0]   q,
  output rhsm_pkg::mr_rsp_t            rsp
);

  logic [rhsm_pkg::MR_PW-1:0]    prod_r, prod_nxt;
  logic [rhsm_pkg::MOD_W-1:0]    rem_r, rem_nxt;
  logic [rhsm_pkg::MR_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [rhsm_pkg::MOD_W:0]      trial;
  logic [rhsm_pkg::MOD_W:0]      q_ext;

  assign q_ext = {1'b0, q};
  // Shift the next product bit into the partial remainder.
  assign trial = {rem_r, prod_r[rhsm_pkg::MR_PW-1]};

  always_comb begin
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      prod_nxt = rhsm_pkg::MR_PW'(req.a) * rhsm_pkg::MR_PW'(req.b)
               + rhsm_pkg::MR_PW'(req.c);
      rem_nxt  = '0;
      cnt_nxt  = rhsm_pkg::MR_CNT_W'(rhsm_pkg::MR_PW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= q_ext) begin
        rem_nxt = rhsm_pkg::MOD_W'(trial - q_ext);
      end else begin
        rem_nxt = rhsm_pkg::MOD_W'(trial);
      end
      prod_nxt = {prod_r[rhsm_pkg::MR_PW-2:0], 1'b0};
      cnt_nxt  = cnt_r - rhsm_pkg::MR_CNT_W'(1);
      if (cnt_r == rhsm_pkg::MR_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTH
  a_no_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("modular unit started while busy");

  a_done_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == rhsm_pkg::MR_CNT_W'(1)) |=> rsp.done)
    else $error("modular unit missed its done pulse");

  a_rem_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r || rsp.done) |-> ({1'b0, rem_r} < q_ext))
    else $error("partial remainder not below modulus");
`endif

endmodule

@@ rtl/rhsm_bytes.sv @@
// ----------------------------------------------------------------------------
// Pattern store and text window memories
// Two byte memories with one write and one registered read port each.
// ----------------------------------------------------------------------------
module rhsm_bytes #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IW    = 5
) (
  input  logic                        clk,
  input  logic                        pat_we,
  input  logic [IW-1:0]               pat_waddr,
  input  logic [rhsm_pkg::BYTE_W-1:0] pat_wdata,
  input  logic [IW-1:0]               pat_raddr,
  output logic [rhsm_pkg::BYTE_W-1:0] pat_rdata,
  input  logic                        txt_we,
  input  logic [IW-1:0]               txt_waddr,
  input  logic [rhsm_pkg::BYTE_W-1:0] txt_wdata,
  input  logic [IW-1:0]               txt_raddr,
  output logic [rhsm_pkg::BYTE_W-1:0] txt_rdata
);

  logic [rhsm_pkg::BYTE_W-1:0] pat_mem [DEPTH];
  logic [rhsm_pkg::BYTE_W-1:0] txt_mem [DEPTH];
  logic [rhsm_pkg::BYTE_W-1:0] pat_rdata_r;
  logic [rhsm_pkg::BYTE_W-1:0] txt_rdata_r;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pat_wdata;
    end
    pat_rdata_r <= pat_mem[pat_raddr];
  end

  // The text memory is a ring: the oldest window byte is overwritten in place.
  always_ff @(posedge clk) begin
    if (txt_we) begin
      txt_mem[txt_waddr] <= txt_wdata;
    end
    txt_rdata_r <= txt_mem[txt_raddr];
  end

  assign pat_rdata = pat_rdata_r;
  assign txt_rdata = txt_rdata_r;

endmodule

@@ rtl/rolling_hash_string_match.sv @@
// ----------------------------------------------------------------------------
// Rolling hash string matcher
// Stores a pattern, rolls a polynomial hash over the text and confirms hash
// hits byte by byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_item  (action, byte, restart)
//   out_     output     out_valid / out_ready  out_item (full, hit, match, shift)
//   cfg      input      psel/penable/pready    radix at 0x0, modulus at 0x4
//
// A pattern item runs the hash step and, for every byte after the first, the
// power step; a text item runs the hash step while the window fills, and the
// oldest byte's term and then the hash once it slides, plus a byte-by-byte
// compare when the hashes agree. Every step goes through the shared modular
// unit, which reduces a 41-bit product by one remainder bit per cycle.
// Reset is synchronous and active low; no memory clearing pass is needed, as
// fill counts guard every read.
// A finished result waits in the output register, and the next item is taken
// meanwhile; the block stalls only when a second result is ready before the
// first one has been taken.
// ----------------------------------------------------------------------------
module rolling_hash_string_match #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rhsm_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rhsm_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rhsm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rhsm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rhsm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  // IW indexes the byte memories, LW holds a length up to MAX_PATTERN itself.
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] MAXL = LW'(MAX_PATTERN);

  // Configuration registers.
  logic [rhsm_pkg::RADIX_W-1:0] radix_r;
  logic [rhsm_pkg::MOD_W-1:0]   modulus_r;
  logic [rhsm_pkg::MOD_W-1:0]   q_eff;

  // Sequencer and hash state.
  rhsm_pkg::state_t              state_r, state_nxt;
  logic [LW-1:0]                 plen_r, plen_nxt;
  logic [rhsm_pkg::MOD_W-1:0]    ph_r, ph_nxt;
  logic [rhsm_pkg::MOD_W-1:0]    lp_r, lp_nxt;
  logic [rhsm_pkg::MOD_W-1:0]    th_r, th_nxt;
  logic [LW-1:0]                 fill_r, fill_nxt;
  logic [IW-1:0]                 start_r, start_nxt;
  logic [rhsm_pkg::SHIFT_W-1:0]  count_r, count_nxt;
  logic [rhsm_pkg::SHIFT_W-1:0]  pos_r, pos_nxt;
  logic [rhsm_pkg::BYTE_W-1:0]   byte_r, byte_nxt;
  logic [rhsm_pkg::MR_A_W-1:0]   diff_r, diff_nxt;
  logic [IW-1:0]                 ci_r, ci_nxt;
  logic [IW-1:0]                 ti_r, ti_nxt;
  logic                          full_r, full_nxt;
  logic                          hit_r, hit_nxt;
  logic                          eq_r, eq_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rhsm_pkg::out_item_t           out_item_r, out_item_nxt;

  // Unit and memory hookup.
  rhsm_pkg::mr_req_t             mr_req;
  rhsm_pkg::mr_rsp_t             mr_rsp;
  logic                          pat_we;
  logic                          txt_we;
  logic [IW-1:0]                 txt_waddr;
  logic [rhsm_pkg::BYTE_W-1:0]   pat_rdata;
  logic [rhsm_pkg::BYTE_W-1:0]   txt_rdata;
  logic [LW-1:0]                 fill_eff;

  // Step a ring index, wrapping at the pattern length.
  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                             input logic [LW-1:0] len);
    logic [LW-1:0] s;
    s = LW'(idx) + LW'(1);
    return (s == len) ? '0 : s[IW-1:0];
  endfunction

  // A modulus of zero acts as one, which makes every hash zero.
  assign q_eff = (modulus_r == '0) ? rhsm_pkg::MOD_W'(1) : modulus_r;

  // --------------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle; reads are immediate.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r   <= rhsm_pkg::RADIX_RST;
      modulus_r <= rhsm_pkg::MODULUS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        rhsm_pkg::REG_RADIX:   radix_r   <= pwdata[rhsm_pkg::RADIX_W-1:0];
        rhsm_pkg::REG_MODULUS: modulus_r <= pwdata[rhsm_pkg::MOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rhsm_pkg::REG_RADIX:   prdata = rhsm_pkg::APB_DATA_W'(radix_r);
      rhsm_pkg::REG_MODULUS: prdata = rhsm_pkg::APB_DATA_W'(modulus_r);
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // --------------------------------------------------------------------------
  // Sequencer. Every hash update goes through the one modular unit: a pattern
  // byte needs the hash step and, after the first byte, the power step; a sliding
  // text byte needs the oldest byte's term and then the new hash. The difference
  // th + q - term is fed straight into the second product, which is congruent to
  // reducing it first. On a hash hit the window is compared with the pattern one
  // byte at a time, reading then checking each, up to the first mismatch.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    plen_nxt      = plen_r;
    ph_nxt        = ph_r;
    lp_nxt        = lp_r;
    th_nxt        = th_r;
    fill_nxt      = fill_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    byte_nxt      = byte_r;
    diff_nxt      = diff_r;
    ci_nxt        = ci_r;
    ti_nxt        = ti_r;
    full_nxt      = full_r;
    hit_nxt       = hit_r;
    eq_nxt        = eq_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    mr_req        = '0;
    pat_we        = 1'b0;
    txt_we        = 1'b0;
    txt_waddr     = start_r;
    fill_eff      = in_item.restart ? '0 : fill_r;
    in_ready      = 1'b0;

    unique case (state_r)
      rhsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          byte_nxt = in_item.byte_value;
          if (in_item.action == rhsm_pkg::ACT_PATTERN) begin
            // Any pattern byte invalidates the text window.
            fill_nxt  = '0;
            count_nxt = '0;
            th_nxt    = '0;
            start_nxt = '0;
            if (in_item.restart) begin
              plen_nxt = '0;
              ph_nxt   = '0;
              lp_nxt   = rhsm_pkg::MOD_W'(1);
            end
            state_nxt = rhsm_pkg::ST_PHASH;
          end else begin
            pos_nxt   = in_item.restart ? '0 : count_r;
            count_nxt = (in_item.restart ? '0 : count_r) + rhsm_pkg::SHIFT_W'(1);
            ti_nxt    = in_item.restart ? '0 : start_r;
            full_nxt  = 1'b0;
            hit_nxt   = 1'b0;
            eq_nxt    = 1'b0;
            if (in_item.restart) begin
              fill_nxt  = '0;
              th_nxt    = '0;
              start_nxt = '0;
            end
            if (plen_r == '0) begin
              state_nxt = rhsm_pkg::ST_OUT;
            end else if (fill_eff < plen_r) begin
              state_nxt = rhsm_pkg::ST_TFILL;
            end else begin
              state_nxt = rhsm_pkg::ST_SRD;
            end
          end
        end
      end

      rhsm_pkg::ST_PHASH: begin
        // Bytes past the end of the store are dropped.
        if (plen_r < MAXL) begin
          mr_req.start = 1'b1;
          mr_req.a     = rhsm_pkg::MR_A_W'(ph_r);
          mr_req.b     = radix_r;
          mr_req.c     = byte_r;
          pat_we       = 1'b1;
          state_nxt    = rhsm_pkg::ST_PHASH_W;
        end else begin
          state_nxt = rhsm_pkg::ST_IDLE;
        end
      end

      rhsm_pkg::ST_PHASH_W: begin
        if (mr_rsp.done) begin
          ph_nxt = mr_rsp.rem;
          if (plen_r == '0) begin
            lp_nxt    = (q_eff == rhsm_pkg::MOD_W'(1)) ? '0 : rhsm_pkg::MOD_W'(1);
            plen_nxt  = plen_r + LW'(1);
            state_nxt = rhsm_pkg::ST_IDLE;
          end else begin
            state_nxt = rhsm_pkg::ST_PPOW;
          end
        end
      end

      rhsm_pkg::ST_PPOW: begin
        mr_req.start = 1'b1;
        mr_req.a     = rhsm_pkg::MR_A_W'(lp_r);
        mr_req.b     = radix_r;
        mr_req.c     = '0;
        state_nxt    = rhsm_pkg::ST_PPOW_W;
      end

      rhsm_pkg::ST_PPOW_W: begin
        if (mr_rsp.done) begin
          lp_nxt    = mr_rsp.rem;
          plen_nxt  = plen_r + LW'(1);
          state_nxt = rhsm_pkg::ST_IDLE;
        end
      end

      rhsm_pkg::ST_TFILL: begin
        mr_req.start = 1'b1;
        mr_req.a     = rhsm_pkg::MR_A_W'(th_r);
        mr_req.b     = radix_r;
        mr_req.c     = byte_r;
        txt_we       = 1'b1;
        txt_waddr    = fill_r[IW-1:0];
        state_nxt    = rhsm_pkg::ST_TFILL_W;
      end

      rhsm_pkg::ST_TFILL_W: begin
        if (mr_rsp.done) begin
          th_nxt    = mr_rsp.rem;
          fill_nxt  = fill_r + LW'(1);
          state_nxt = rhsm_pkg::ST_EVAL;
        end
      end

      rhsm_pkg::ST_SRD: begin
        // The ring read of the oldest byte is issued here.
        state_nxt = rhsm_pkg::ST_STERM;
      end

      rhsm_pkg::ST_STERM: begin
        mr_req.start = 1'b1;
        mr_req.a     = rhsm_pkg::MR_A_W'(lp_r);
        mr_req.b     = rhsm_pkg::RADIX_W'(txt_rdata);
        mr_req.c     = '0;
        state_nxt    = rhsm_pkg::ST_STERM_W;
      end

      rhsm_pkg::ST_STERM_W: begin
        if (mr_rsp.done) begin
          diff_nxt  = rhsm_pkg::MR_A_W'(th_r) + rhsm_pkg::MR_A_W'(q_eff)
                    - rhsm_pkg::MR_A_W'(mr_rsp.rem);
          state_nxt = rhsm_pkg::ST_SHASH;
        end
      end

      rhsm_pkg::ST_SHASH: begin
        mr_req.start = 1'b1;
        mr_req.a     = diff_r;
        mr_req.b     = radix_r;
        mr_req.c     = byte_r;
        txt_we       = 1'b1;
        txt_waddr    = start_r;
        start_nxt    = wrap_inc(start_r, plen_r);
        state_nxt    = rhsm_pkg::ST_SHASH_W;
      end

      rhsm_pkg::ST_SHASH_W: begin
        if (mr_rsp.done) begin
          th_nxt    = mr_rsp.rem;
          state_nxt = rhsm_pkg::ST_EVAL;
        end
      end

      rhsm_pkg::ST_EVAL: begin
        ci_nxt   = '0;
        ti_nxt   = start_r;
        full_nxt = (fill_r >= plen_r);
        hit_nxt  = (fill_r >= plen_r) && (th_r == ph_r);
        eq_nxt   = 1'b0;
        if ((fill_r >= plen_r) && (th_r == ph_r)) begin
          state_nxt = rhsm_pkg::ST_CMP_RD;
        end else begin
          state_nxt = rhsm_pkg::ST_OUT;
        end
      end

      rhsm_pkg::ST_CMP_RD: begin
        state_nxt = rhsm_pkg::ST_CMP_CHK;
      end

      rhsm_pkg::ST_CMP_CHK: begin
        if (pat_rdata != txt_rdata) begin
          eq_nxt    = 1'b0;
          state_nxt = rhsm_pkg::ST_OUT;
        end else if (LW'(ci_r) == plen_r - LW'(1)) begin
          eq_nxt    = 1'b1;
          state_nxt = rhsm_pkg::ST_OUT;
        end else begin
          ci_nxt    = ci_r + IW'(1);
          ti_nxt    = wrap_inc(ti_r, plen_r);
          state_nxt = rhsm_pkg::ST_CMP_RD;
        end
      end

      rhsm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt.window_full = full_r;
          out_item_nxt.hash_hit    = hit_r;
          out_item_nxt.match       = eq_r;
          out_item_nxt.shift       = full_r
                                   ? pos_r - rhsm_pkg::SHIFT_W'(plen_r)
                                     + rhsm_pkg::SHIFT_W'(1)
                                   : '0;
          out_valid_nxt = 1'b1;
          state_nxt     = rhsm_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rhsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhsm_pkg::ST_IDLE;
      plen_r      <= '0;
      ph_r        <= '0;
      lp_r        <= rhsm_pkg::MOD_W'(1);
      th_r        <= '0;
      fill_r      <= '0;
      start_r     <= '0;
      count_r     <= '0;
      ci_r        <= '0;
      ti_r        <= '0;
      full_r      <= 1'b0;
      hit_r       <= 1'b0;
      eq_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      ph_r        <= ph_nxt;
      lp_r        <= lp_nxt;
      th_r        <= th_nxt;
      fill_r      <= fill_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
      ci_r        <= ci_nxt;
      ti_r        <= ti_nxt;
      full_r      <= full_nxt;
      hit_r       <= hit_nxt;
      eq_r        <= eq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    byte_r     <= byte_nxt;
    diff_r     <= diff_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  rhsm_modred u_modred (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mr_req),
    .q     (q_eff),
    .rsp   (mr_rsp)
  );

  rhsm_bytes #(
    .DEPTH (MAX_PATTERN),
    .IW    (IW)
  ) u_bytes (
    .clk       (clk),
    .pat_we    (pat_we),
    .pat_waddr (plen_r[IW-1:0]),
    .pat_wdata (byte_r),
    .pat_raddr (ci_r),
    .pat_rdata (pat_rdata),
    .txt_we    (txt_we),
    .txt_waddr (txt_waddr),
    .txt_wdata (byte_r),
    .txt_raddr (ti_r),
    .txt_rdata (txt_rdata)
  );

`ifndef SYNTH
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= plen_r)
    else $error("window fill exceeds pattern length");

  a_ring_start : assert property (@(posedge clk) disable iff (!rst_n)
    (plen_r != '0) |-> (LW'(start_r) < plen_r))
    else $error("ring start pointer outside the window");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("waiting result changed before it was taken");
`endif

endmodule
